// ===== sv/assert_macros.svh =====
// Assertion macros used by the echo block's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fde_pkg.sv =====
// Shared constants and types of the feedback delay echo.
package fde_pkg;

  localparam int STORE_DEPTH_DEF = 131072;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int GAIN_BITS  = 16;
  localparam int GAIN_FRAC  = 14;
  localparam int GAIN_HALF  = 1 << (GAIN_FRAC - 1);
  localparam int DELAY_BITS = 17;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = DELAY_BITS;

  localparam logic [GAIN_BITS-1:0]  INPUT_GAIN_RST    = 16'd16384;
  localparam logic [GAIN_BITS-1:0]  FEEDBACK_GAIN_RST = 16'd9830;
  localparam logic [DELAY_BITS-1:0] DELAY_RST         = 17'd4800;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INPUT_GAIN,
    REG_FEEDBACK_GAIN,
    REG_DELAY_SAMPLES
  } cfg_reg_t;

endpackage

// ===== sv/fde_in_if.sv =====
// Input frame channel: valid, ready and one stereo sample pair.
interface fde_in_if #(
  parameter int SAMPLE_BITS = fde_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

// ===== sv/fde_out_if.sv =====
// Output frame channel: valid, ready and one stereo sample pair.
interface fde_out_if #(
  parameter int SAMPLE_BITS = fde_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== sv/fde_ram.sv =====
// Generic simple dual-port RAM with registered read.
module fde_ram #(
  parameter int WIDTH = 2 * fde_pkg::SAMPLE_BITS_DEF,
  parameter int DEPTH = fde_pkg::STORE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== sv/feedback_delay_echo.sv =====
// Stereo feedback delay-line echo built around one shared sample RAM.
//
//   channel  dir  role                 beat content
//   din      in   frame source         left_in, right_in (signed samples)
//   dout     out  echo result          left_out, right_out (signed samples)
//   cfg_*    in   register write port  cfg_idx selects gain or delay register
//
// One frame per cycle unless a hazard, delay reduction or output stall holds it;
// the result passes the stage 1, 2 and 3 registers into the output register.
// A frame whose read slot is still pending write by a frame in flight (delay
// modulo depth of 1, 2 or 3) waits; at delay 1 each frame waits for the previous write.
// After reset and after each delay write, a reciprocal multiply and then one subtract
// reduce the delay modulo the depth; no frame is accepted meanwhile.
// Reset needs no clearing pass: a wrap flag marks slots not yet written as zero.
// A stalled output stalls the stages behind it; empty stages still fill.
`include "assert_macros.svh"

module feedback_delay_echo #(
  parameter int STORE_DEPTH = fde_pkg::STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS = fde_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  fde_in_if.sink                             din,
  fde_out_if.source                          dout,
  input  logic                               cfg_en,
  input  logic [fde_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  logic [fde_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int SB = SAMPLE_BITS;
  localparam int GB = fde_pkg::GAIN_BITS;
  localparam int GF = fde_pkg::GAIN_FRAC;
  localparam int PW = SB + GB + 1;
  localparam int TW = PW - GF - SB + 1;
  localparam int DB = fde_pkg::DELAY_BITS;
  localparam int RW = DB + 2;
  localparam int RK = DB + AW;
  localparam longint RECIP_L =
    ((longint'(1) << RK) + longint'(STORE_DEPTH) - longint'(1)) / longint'(STORE_DEPTH);
  localparam logic [RW-1:0]    RECIP   = RW'(RECIP_L);
  localparam logic [DB+AW-1:0] DEPTH_X = (DB + AW)'(STORE_DEPTH);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(STORE_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(STORE_DEPTH - 1);
  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB - 1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB - 1){1'b0}}};

  // Round half up, drop the gain fraction, saturate to a sample
  function automatic logic signed [SB-1:0] scale_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    logic [TW-1:0]        top;
    r   = p + PW'(fde_pkg::GAIN_HALF);
    top = r[PW-1:GF+SB-1];
    if ((&top) || !(|top)) begin
      return $signed(r[GF+SB-1:GF]);
    end
    return r[PW-1] ? SMIN : SMAX;
  endfunction

  // Saturate a sum of two samples
  function automatic logic signed [SB-1:0] sum_sat(input logic signed [SB:0] s);
    if (s[SB] == s[SB-1]) begin
      return $signed(s[SB-1:0]);
    end
    return s[SB] ? SMIN : SMAX;
  endfunction

  // Configuration registers
  logic [GB-1:0] input_gain;
  logic [GB-1:0] feedback_gain;
  logic [DB-1:0] delay_raw;

  // Delay modulo unit
  logic             red_busy;
  logic             red_phase;
  logic [DB-1:0]    red_q;
  logic [DB+RW-1:0] red_prod;
  logic [DB+AW-1:0] red_qd;
  logic [AW-1:0]    delay_mod;

  // Write position and wrap flag
  logic [AW-1:0] wr_pos;
  logic          wrapped;

  // Stage 0 address logic
  logic [AW:0]   diff0;
  logic [AW-1:0] rd0;
  logic          rv0;
  logic          dz0;
  logic          hazard;
  logic          accept;
  logic signed [PW-1:0] pl0, pr0;

  // Pipeline stages
  logic          v1, v2, v3;
  logic          adv1, adv2, adv3, adv_o;
  logic signed [PW-1:0] pl1, pr1;
  logic [AW-1:0] wa1, wa2, wa3;
  logic          rv1, dz1;
  logic signed [SB-1:0] il1, ir1, sl1, sr1;
  logic signed [SB-1:0] il2, ir2, sl2, sr2;
  logic signed [PW-1:0] fl2, fr2;
  logic signed [SB-1:0] il3, ir3;
  logic signed [PW-1:0] fl3, fr3;
  logic signed [SB-1:0] out_l3, out_r3, sum_l3, sum_r3;

  // RAM ports
  logic              ram_we, ram_re;
  logic [2*SB-1:0]   ram_wdata, ram_rdata;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain    <= fde_pkg::INPUT_GAIN_RST;
      feedback_gain <= fde_pkg::FEEDBACK_GAIN_RST;
      delay_raw     <= fde_pkg::DELAY_RST;
    end else if (cfg_en) begin
      unique case (fde_pkg::cfg_reg_t'(cfg_idx))
        fde_pkg::REG_INPUT_GAIN:    input_gain    <= cfg_data[GB-1:0];
        fde_pkg::REG_FEEDBACK_GAIN: feedback_gain <= cfg_data[GB-1:0];
        fde_pkg::REG_DELAY_SAMPLES: delay_raw     <= cfg_data[DB-1:0];
        default: ;
      endcase
    end
  end

  // Reduce the delay modulo the depth: quotient by reciprocal, then subtract
  assign red_prod = delay_raw * RECIP;
  assign red_qd   = {{AW{1'b0}}, red_q} * DEPTH_X;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_busy  <= 1'b1;
      red_phase <= 1'b0;
      red_q     <= '0;
      delay_mod <= '0;
    end else if (cfg_en && (fde_pkg::cfg_reg_t'(cfg_idx) == fde_pkg::REG_DELAY_SAMPLES)) begin
      red_busy  <= 1'b1;
      red_phase <= 1'b0;
    end else if (red_busy) begin
      if (!red_phase) begin
        red_q     <= DB'(red_prod >> RK);
        red_phase <= 1'b1;
      end else begin
        delay_mod <= AW'({{AW{1'b0}}, delay_raw} - red_qd);
        red_busy  <= 1'b0;
      end
    end
  end

  // Read address, written-slot check and hazard check
  always_comb begin
    diff0  = {1'b0, wr_pos} - {1'b0, delay_mod};
    rd0    = diff0[AW] ? AW'(diff0 + DEPTH_W) : diff0[AW-1:0];
    rv0    = wrapped || (rd0 < wr_pos);
    dz0    = (delay_mod == '0);
    hazard = (v1 && (wa1 == rd0)) || (v2 && (wa2 == rd0)) || (v3 && (wa3 == rd0));
  end

  // Stage advance chain
  assign adv_o = !dout.valid || dout.ready;
  assign adv3  = !v3 || adv_o;
  assign adv2  = !v2 || adv3;
  assign adv1  = !v1 || adv2;

  assign din.ready = adv1 && !hazard && !red_busy;
  assign accept    = din.valid && din.ready;

  // Input gain products
  assign pl0 = din.left_in  * $signed({1'b0, input_gain});
  assign pr0 = din.right_in * $signed({1'b0, input_gain});

  // Advance the write position
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos  <= '0;
      wrapped <= 1'b0;
    end else if (accept) begin
      if (wr_pos == LAST) begin
        wr_pos  <= '0;
        wrapped <= 1'b1;
      end else begin
        wr_pos <= wr_pos + AW'(1);
      end
    end
  end

  // Stage 1: scale input, pick the delayed sample
  always_comb begin
    il1 = scale_sat(pl1);
    ir1 = scale_sat(pr1);
    if (dz1) begin
      sl1 = il1;
      sr1 = ir1;
    end else if (rv1) begin
      sl1 = $signed(ram_rdata[2*SB-1:SB]);
      sr1 = $signed(ram_rdata[SB-1:0]);
    end else begin
      sl1 = '0;
      sr1 = '0;
    end
  end

  // Stage 2: feedback gain products
  assign fl2 = sl2 * $signed({1'b0, feedback_gain});
  assign fr2 = sr2 * $signed({1'b0, feedback_gain});

  // Stage 3: output and feedback sum
  always_comb begin
    out_l3 = scale_sat(fl3);
    out_r3 = scale_sat(fr3);
    sum_l3 = sum_sat({il3[SB-1], il3} + {out_l3[SB-1], out_l3});
    sum_r3 = sum_sat({ir3[SB-1], ir3} + {out_r3[SB-1], out_r3});
  end

  assign ram_re    = accept;
  assign ram_we    = v3 && adv_o;
  assign ram_wdata = {sum_l3, sum_r3};

  // Stage valid bits and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= accept;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
      if (adv_o) begin
        dout.valid <= v3;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv1) begin
      pl1 <= pl0;
      pr1 <= pr0;
      wa1 <= wr_pos;
      rv1 <= rv0;
      dz1 <= dz0;
    end
    if (adv2) begin
      il2 <= il1;
      ir2 <= ir1;
      sl2 <= sl1;
      sr2 <= sr1;
      wa2 <= wa1;
    end
    if (adv3) begin
      il3 <= il2;
      ir3 <= ir2;
      fl3 <= fl2;
      fr3 <= fr2;
      wa3 <= wa2;
    end
    if (adv_o && v3) begin
      dout.left_out  <= out_l3;
      dout.right_out <= out_r3;
    end
  end

  fde_ram #(
    .WIDTH (2 * SB),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wa3),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd0),
    .rdata (ram_rdata)
  );

  `ASSERT_IMPL(a_no_accept_busy, clk, rst, din.valid && din.ready, !red_busy, "accept while busy")
  `ASSERT_IMPL(a_no_rw_clash, clk, rst, ram_we && ram_re, wa3 != rd0, "slot read and written at once")
  `ASSERT_NEXT(a_wrap_holds, clk, rst, wrapped, wrapped, "wrap flag dropped")
  `ASSERT_NEXT(a_out_from_s3, clk, rst, !dout.valid && !v3, !dout.valid, "beat from empty stage 3")

endmodule
